@@ rtl/pcc_pkg.sv @@
// Shared constants, codes and control/status types of the permutation cycle counter.
package pcc_pkg;

	localparam int BOARD_SIZE = 1024;
	localparam int IDX_W      = $clog2(BOARD_SIZE);
	localparam int POS_W      = 11;
	localparam int CNT_W      = 11;
	localparam int CYC_W      = IDX_W;
	localparam int SUM_W      = CNT_W + 1;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BOARD_SIZE - 1);

	// Visit colors kept with each row in the mark store.
	localparam logic [1:0] COL_NEW  = 2'd0;
	localparam logic [1:0] COL_PATH = 2'd1;
	localparam logic [1:0] COL_DONE = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOAD,
		S_SCAN_RD,
		S_SCAN,
		S_WALK,
		S_RET,
		S_DONE
	} pcc_state_t;

	typedef enum logic [2:0] {
		RD_ROW,
		RD_SCAN,
		RD_SCAN_NEXT,
		RD_SUCC,
		RD_START
	} pcc_rd_sel_t;

	typedef enum logic [2:0] {
		MW_NONE,
		MW_LOAD,
		MW_PATH,
		MW_DONE,
		MW_CLEAR
	} pcc_mark_wr_t;

	typedef struct packed {
		pcc_rd_sel_t  rd_sel;
		pcc_mark_wr_t mark_wr;
		logic         succ_we;
		logic         cap;
		logic         clr_step;
		logic         scan_clr;
		logic         scan_inc;
		logic         walk_begin;
		logic         count_piece;
		logic         set_conflict;
		logic         count_cycle;
		logic         emit;
	} pcc_cmd_t;

	typedef struct packed {
		logic       piece_ok;
		logic       last;
		logic       occ;
		logic [1:0] color;
		logic       scan_end;
		logic       clr_end;
	} pcc_stat_t;

endpackage

@@ rtl/pcc_ctrl.sv @@
// Controller state machine of the permutation cycle counter.
module pcc_ctrl import pcc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  pcc_stat_t stat,
	output pcc_cmd_t  cmd,
	output logic      busy
);

	pcc_state_t state_q;
	pcc_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		cmd     = '0;
		cmd.rd_sel  = RD_SCAN;
		cmd.mark_wr = MW_NONE;
		unique case (state_q)
			S_CLEAR: begin
				cmd.mark_wr  = MW_CLEAR;
				cmd.clr_step = 1'b1;
				if (stat.clr_end) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				busy       = 1'b0;
				cmd.rd_sel = RD_ROW;
				if (start) begin
					cmd.cap = 1'b1;
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				if (stat.piece_ok) begin
					cmd.count_piece = 1'b1;
					if (stat.occ) begin
						cmd.set_conflict = 1'b1;
					end else begin
						cmd.mark_wr = MW_LOAD;
						cmd.succ_we = 1'b1;
					end
				end
				if (stat.last) begin
					cmd.scan_clr = 1'b1;
					state_d      = S_SCAN_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SCAN_RD: begin
				cmd.rd_sel = RD_SCAN;
				state_d    = S_SCAN;
			end
			S_SCAN: begin
				if (stat.occ && stat.color == COL_NEW) begin
					cmd.mark_wr    = MW_PATH;
					cmd.walk_begin = 1'b1;
					cmd.rd_sel     = RD_SUCC;
					state_d        = S_WALK;
				end else if (stat.scan_end) begin
					state_d = S_DONE;
				end else begin
					cmd.scan_inc = 1'b1;
					cmd.rd_sel   = RD_SCAN_NEXT;
				end
			end
			S_WALK: begin
				if (stat.occ && stat.color == COL_NEW) begin
					cmd.mark_wr = MW_PATH;
					cmd.rd_sel  = RD_SUCC;
				end else begin
					// Meeting a row of the current path closes a cycle.
					cmd.count_cycle = stat.occ && stat.color == COL_PATH;
					cmd.rd_sel      = RD_START;
					state_d         = S_RET;
				end
			end
			S_RET: begin
				if (stat.occ && stat.color == COL_PATH) begin
					cmd.mark_wr = MW_DONE;
					cmd.rd_sel  = RD_SUCC;
				end else if (stat.scan_end) begin
					state_d = S_DONE;
				end else begin
					cmd.scan_inc = 1'b1;
					cmd.rd_sel   = RD_SCAN_NEXT;
					state_d      = S_SCAN;
				end
			end
			S_DONE: begin
				cmd.emit = 1'b1;
				state_d  = S_CLEAR;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	a_walk_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> $past(state_q) == S_SCAN || $past(state_q) == S_WALK)
		else $error("walk entered from an unexpected state");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && !start |=> state_q == S_IDLE)
		else $error("left idle without a transaction");

	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> state_q == S_CLEAR)
		else $error("result not followed by the clearing pass");

endmodule

@@ rtl/pcc_datapath.sv @@
// Datapath of the permutation cycle counter: tables, pointers, counts and result registers.
module pcc_datapath import pcc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [POS_W-1:0] row,
	input  logic [POS_W-1:0] column,
	input  logic             last,
	input  pcc_cmd_t         cmd,
	output pcc_stat_t        stat,
	output logic [CNT_W-1:0] moves,
	output logic             conflict,
	output logic             done
);

	// Mark store: bit 2 is occupied, bits 1:0 the visit color.
	logic [2:0]       mark_mem [BOARD_SIZE];
	logic [IDX_W-1:0] succ_mem [BOARD_SIZE];

	logic [2:0]       mark_rd_s1;
	logic [IDX_W-1:0] succ_rd_s1;
	logic [IDX_W-1:0] addr_s1;

	logic [POS_W-1:0] row_q;
	logic [POS_W-1:0] col_q;
	logic             last_q;
	logic [IDX_W-1:0] start_q;
	logic [IDX_W-1:0] scan_q;
	logic [IDX_W-1:0] clr_q;
	logic [CNT_W-1:0] offdiag_q;
	logic [CYC_W-1:0] cycles_q;
	logic             conflict_seen_q;
	logic [CNT_W-1:0] moves_q;
	logic             conflict_q;
	logic             done_q;

	logic [IDX_W-1:0] rd_addr;
	logic             mark_we;
	logic [IDX_W-1:0] mark_wa;
	logic [2:0]       mark_wd;
	logic [IDX_W-1:0] col_idx;
	logic [SUM_W-1:0] sum;

	assign col_idx = IDX_W'(col_q - POS_W'(1));

	always_comb begin
		unique case (cmd.rd_sel)
			RD_ROW:       rd_addr = IDX_W'(row - POS_W'(1));
			RD_SCAN:      rd_addr = scan_q;
			RD_SCAN_NEXT: rd_addr = IDX_W'(scan_q + 1'b1);
			RD_SUCC:      rd_addr = succ_rd_s1;
			RD_START:     rd_addr = start_q;
			default:      rd_addr = scan_q;
		endcase
	end

	always_comb begin
		mark_we = 1'b1;
		mark_wa = addr_s1;
		mark_wd = 3'b000;
		unique case (cmd.mark_wr)
			MW_NONE:  mark_we = 1'b0;
			MW_LOAD:  mark_wd = {1'b1, COL_NEW};
			MW_PATH:  mark_wd = {1'b1, COL_PATH};
			MW_DONE:  mark_wd = {1'b1, COL_DONE};
			MW_CLEAR: mark_wa = clr_q;
			default:  mark_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_wa] <= mark_wd;
		end
		mark_rd_s1 <= mark_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.succ_we) begin
			succ_mem[addr_s1] <= col_idx;
		end
		succ_rd_s1 <= succ_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		if (cmd.cap) begin
			row_q  <= row;
			col_q  <= column;
			last_q <= last;
		end
		if (cmd.walk_begin) begin
			start_q <= addr_s1;
		end
		if (cmd.emit) begin
			moves_q    <= sum[SUM_W-1] ? '1 : sum[CNT_W-1:0];
			conflict_q <= conflict_seen_q;
		end
	end

	assign sum = {1'b0, offdiag_q} + SUM_W'(cycles_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q          <= '0;
			clr_q           <= '0;
			offdiag_q       <= '0;
			cycles_q        <= '0;
			conflict_seen_q <= 1'b0;
			done_q          <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.clr_step) begin
				clr_q <= (clr_q == IDX_LAST) ? '0 : IDX_W'(clr_q + 1'b1);
			end
			if (cmd.scan_clr) begin
				scan_q <= '0;
			end else if (cmd.scan_inc) begin
				scan_q <= IDX_W'(scan_q + 1'b1);
			end
			if (cmd.emit) begin
				offdiag_q       <= '0;
				cycles_q        <= '0;
				conflict_seen_q <= 1'b0;
			end else begin
				if (cmd.count_piece && offdiag_q != '1) begin
					offdiag_q <= CNT_W'(offdiag_q + 1'b1);
				end
				if (cmd.count_cycle) begin
					cycles_q <= CYC_W'(cycles_q + 1'b1);
				end
				if (cmd.set_conflict) begin
					conflict_seen_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		stat.piece_ok = (row_q != col_q) && (row_q != '0) && (col_q != '0) &&
		                (32'(row_q) <= 32'(BOARD_SIZE)) && (32'(col_q) <= 32'(BOARD_SIZE));
		stat.last     = last_q;
		stat.occ      = mark_rd_s1[2];
		stat.color    = mark_rd_s1[1:0];
		stat.scan_end = (scan_q == IDX_LAST);
		stat.clr_end  = (clr_q == IDX_LAST);
	end

	assign moves    = moves_q;
	assign conflict = conflict_q;
	assign done     = done_q;

endmodule

@@ rtl/permutation_cycle_counter.sv @@
// Top level of the permutation cycle counter: controller and datapath.
//
// The block collects one set of piece positions (row, column, both 1-based), one
// transaction per piece, and answers once per set on the transaction flagged last.
// A piece is taken at a rising edge where start is high and busy is low. Pieces on
// the diagonal or out of range are ignored; every other piece is counted and stores
// the edge row -> column in a successor table. A row given twice keeps its first
// entry and raises conflict. After the last piece the controller scans all
// BOARD_SIZE rows and, from each occupied row not yet visited, follows successors
// one row per clock, marking the path, then follows it again to retire it; a path
// that comes back to itself counts one cycle. The result (moves = off-diagonal
// pieces plus cycles, saturated at 2047, and conflict) is shown for exactly one
// clock with done high. There is no back-pressure on the result: the receiver must
// take it in that cycle. An ordinary piece keeps busy high for one cycle after it is
// taken, while it is loaded, and the block then goes back to idle for the next piece;
// the set's last piece adds a scan of all BOARD_SIZE rows plus the mark and retire
// walks along each path, all bounded by the single read port of the table memories,
// and then the result is registered. After each result, and after reset, a clearing
// pass wipes the occupancy and color store of all BOARD_SIZE rows one row per clock
// while busy stays high.
module permutation_cycle_counter import pcc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [POS_W-1:0] row,
	input  logic [POS_W-1:0] column,
	input  logic             last,
	output logic             done,
	output logic [CNT_W-1:0] moves,
	output logic             conflict
);

	pcc_cmd_t  cmd;
	pcc_stat_t stat;

	// Sequencing of load, scan, walks, result and clearing pass.
	pcc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Table memories, pointers and counts.
	pcc_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.row      (row),
		.column   (column),
		.last     (last),
		.cmd      (cmd),
		.stat     (stat),
		.moves    (moves),
		.conflict (conflict),
		.done     (done)
	);

endmodule
